### src/kwd_pkg.sv
// ----------------------------------------------------------------------------
// kwd_pkg
// shared types and constants for the three wheel omni drive mixer
// ----------------------------------------------------------------------------
`default_nettype none

package kwd_pkg;

  localparam int AXIS_W    = 8;
  localparam int TURN_W    = 9;
  localparam int MAG2_W    = 16;
  localparam int ROOT_W    = 24;
  localparam int REM_W     = 26;
  localparam int PROJ_W    = 26;
  localparam int TT_W      = 17;
  localparam int PROD_W    = 50;
  localparam int DSUM_W    = 25;
  localparam int NUM_W     = 50;
  localparam int QUO_W     = 8;
  localparam int SQRT_STG  = ROOT_W;
  localparam int DIV_STG   = QUO_W;
  localparam int DEN_SHIFT = 17;

  localparam logic [6:0] DEADZONE_RESET = 7'd20;
  localparam logic signed [AXIS_W-1:0] STRAFE_SPEED = 8'sd127;
  localparam logic signed [PROJ_W-1:0] SQRT3_Q16 = 26'sd113512;
  localparam logic signed [AXIS_W-1:0] DRIVE_MAX = 8'sd127;

  // control that rides with an item into the divider
  typedef struct packed {
    logic vld;
    logic neg;
    logic zero;
  } kwd_ctl_t;

  // values carried alongside the square root pipeline
  typedef struct packed {
    logic signed [PROJ_W-1:0] p_right;
    logic signed [PROJ_W-1:0] p_left;
    logic signed [PROJ_W-1:0] p_tail;
    logic signed [TT_W-1:0]   tt;
    logic [AXIS_W-1:0]        tabs;
  } kwd_side_t;

endpackage

`default_nettype wire

### src/kwd_sqrt.sv
// ----------------------------------------------------------------------------
// kwd_sqrt
// pipelined square root of s * 2^32, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module kwd_sqrt
  import kwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [MAG2_W-1:0] in_s,
  input  wire kwd_side_t         in_side,
  output logic                   out_vld,
  output logic [ROOT_W-1:0]      out_root,
  output kwd_side_t              out_side
);

  logic              vld_r  [0:SQRT_STG];
  logic [MAG2_W-1:0] s_r    [0:SQRT_STG];
  logic [REM_W-1:0]  rem_r  [0:SQRT_STG];
  logic [ROOT_W-1:0] root_r [0:SQRT_STG];
  kwd_side_t         side_r [0:SQRT_STG];

  assign vld_r[0]  = in_vld;
  assign s_r[0]    = in_s;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < SQRT_STG; i++) begin : g_stage
    logic [1:0]         pair;
    logic [REM_W+1:0]   cur;
    logic [REM_W+1:0]   trial;
    logic [REM_W-1:0]   rem_nxt;
    logic [ROOT_W-1:0]  root_nxt;

    // radicand pairs come from s, the low 32 bits are zero
    if (i < MAG2_W/2) begin : g_pair
      assign pair = s_r[i][MAG2_W-1-2*i -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      cur   = {rem_r[i], pair};
      trial = (REM_W+2)'({root_r[i], 2'b01});
      if (cur >= trial) begin
        rem_nxt  = REM_W'(cur - trial);
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cur);
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      s_r[i+1]    <= s_r[i];
      rem_r[i+1]  <= rem_nxt;
      root_r[i+1] <= root_nxt;
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld  = vld_r[SQRT_STG];
  assign out_root = root_r[SQRT_STG];
  assign out_side = side_r[SQRT_STG];

  // root is the floor square root: root^2 + rem equals the radicand
  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (50'(out_root) * 50'(out_root) + 50'(rem_r[SQRT_STG])
                 == 50'({s_r[SQRT_STG], 32'h0})))
    else $error("sqrt remainder mismatch");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (27'(rem_r[SQRT_STG]) <= 27'({out_root, 1'b0})))
    else $error("sqrt remainder too large");

  a_pipe_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |=> vld_r[1])
    else $error("sqrt stage lost an item");

endmodule

`default_nettype wire

### src/kwd_div.sv
// ----------------------------------------------------------------------------
// kwd_div
// pipelined restoring divider with saturation to the drive range
// ----------------------------------------------------------------------------
`default_nettype none

module kwd_div
  import kwd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kwd_ctl_t           in_ctl,
  input  wire logic [NUM_W-1:0]   in_num,
  input  wire logic [DSUM_W-1:0]  in_dsum,
  output logic                    out_vld,
  output logic signed [AXIS_W-1:0] out_drive
);

  kwd_ctl_t          ctl_r  [0:DIV_STG];
  logic [NUM_W-1:0]  rem_r  [0:DIV_STG];
  logic [DSUM_W-1:0] dsum_r [0:DIV_STG];
  logic [QUO_W-1:0]  quo_r  [0:DIV_STG];

  assign ctl_r[0]  = in_ctl;
  assign rem_r[0]  = in_num;
  assign dsum_r[0] = in_dsum;
  assign quo_r[0]  = '0;

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stage
    localparam int SH = DEN_SHIFT + DIV_STG - 1 - j;
    logic [NUM_W-1:0] dsh;
    logic             take;

    assign dsh  = NUM_W'(dsum_r[j]) << SH;
    assign take = (rem_r[j] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1].vld <= 1'b0;
      end else begin
        ctl_r[j+1].vld <= ctl_r[j].vld;
      end
      ctl_r[j+1].neg  <= ctl_r[j].neg;
      ctl_r[j+1].zero <= ctl_r[j].zero;
      rem_r[j+1]      <= take ? (rem_r[j] - dsh) : rem_r[j];
      dsum_r[j+1]     <= dsum_r[j];
      quo_r[j+1]      <= {quo_r[j][QUO_W-2:0], take};
    end
  end

  logic [AXIS_W-1:0] mag;

  // top quotient bit set means the drive is past full scale
  always_comb begin
    if (ctl_r[DIV_STG].zero) begin
      mag = '0;
    end else if (quo_r[DIV_STG][QUO_W-1]) begin
      mag = AXIS_W'(DRIVE_MAX);
    end else begin
      mag = quo_r[DIV_STG];
    end
  end

  assign out_vld   = ctl_r[DIV_STG].vld;
  assign out_drive = ctl_r[DIV_STG].neg ? -$signed(mag) : $signed(mag);

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !ctl_r[DIV_STG].zero)
      |-> (rem_r[DIV_STG] < (NUM_W'(dsum_r[DIV_STG]) << DEN_SHIFT)))
    else $error("divider remainder not below divisor");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ctl.vld && in_dsum == '0) |-> in_ctl.zero)
    else $error("zero divisor not flagged");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_drive != -8'sd128))
    else $error("drive left the saturated range");

endmodule

`default_nettype wire

### src/three_wheel_omni_drive_mixer.sv
// ----------------------------------------------------------------------------
// three_wheel_omni_drive_mixer
// kiwi drive mixer: stick and strafe inputs to three saturated wheel commands
// ----------------------------------------------------------------------------
// each item passes stage 0, stage 1, root, product, numerator, divider, output
// throughput: one item per cycle, busy stays low; set by the 24 stage root
// and 8 stage divider pipelines, one bit per stage
// reset: synchronous rst_n clears all valid bits and loads deadzone 20
// results cannot be stalled, each shows for one cycle with out_valid
`default_nettype none

module three_wheel_omni_drive_mixer
  import kwd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_strafe_left,
  input  wire logic                in_strafe_right,
  input  wire logic signed [7:0]   in_stick_x,
  input  wire logic signed [7:0]   in_stick_y,
  input  wire logic signed [7:0]   in_stick_turn,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [6:0]          cfg_data,
  output logic                     out_valid,
  output logic signed [7:0]        out_right_drive,
  output logic signed [7:0]        out_left_drive,
  output logic signed [7:0]        out_tail_drive
);

  logic [6:0] deadzone_r;
  logic       accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= DEADZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      deadzone_r <= cfg_data;
    end
  end

  // stage 0: strafe override and deadzone
  logic signed [AXIS_W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [TURN_W-1:0] tneg, t_nxt, t_r;
  logic [AXIS_W-1:0]        xabs, yabs, tabs_in;
  logic                     v0_r;

  always_comb begin
    xabs    = in_stick_x[7] ? AXIS_W'(-in_stick_x) : AXIS_W'(in_stick_x);
    yabs    = in_stick_y[7] ? AXIS_W'(-in_stick_y) : AXIS_W'(in_stick_y);
    tneg    = -TURN_W'(in_stick_turn);
    tabs_in = tneg[TURN_W-1] ? AXIS_W'(-tneg) : AXIS_W'(tneg);
    priority if (in_strafe_left) begin
      x_nxt = -STRAFE_SPEED;
      y_nxt = '0;
    end else if (in_strafe_right) begin
      x_nxt = STRAFE_SPEED;
      y_nxt = '0;
    end else begin
      x_nxt = (xabs < AXIS_W'(deadzone_r)) ? '0 : in_stick_x;
      y_nxt = (yabs < AXIS_W'(deadzone_r)) ? '0 : in_stick_y;
    end
    t_nxt = (tabs_in < AXIS_W'(deadzone_r)) ? '0 : tneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    t_r <= t_nxt;
  end

  // stage 1: squared magnitude, projections, turn term
  logic [AXIS_W-1:0]        xm, ym, tm;
  logic [MAG2_W-1:0]        s_nxt, s1_r;
  logic signed [PROJ_W-1:0] xq, yq;
  kwd_side_t                side_nxt, side1_r;
  logic                     v1_r;
  logic [MAG2_W-1:0]        tsq;

  always_comb begin
    xm  = x_r[AXIS_W-1] ? AXIS_W'(-x_r) : AXIS_W'(x_r);
    ym  = y_r[AXIS_W-1] ? AXIS_W'(-y_r) : AXIS_W'(y_r);
    tm  = t_r[TURN_W-1] ? AXIS_W'(-t_r) : AXIS_W'(t_r);
    s_nxt = MAG2_W'(MAG2_W'(xm) * MAG2_W'(xm) + MAG2_W'(ym) * MAG2_W'(ym));
    tsq   = MAG2_W'(tm) * MAG2_W'(tm);
    xq    = PROJ_W'(x_r) <<< 16;
    yq    = PROJ_W'(y_r) * SQRT3_Q16;
    side_nxt.p_right = -xq + yq;
    side_nxt.p_left  = -xq - yq;
    side_nxt.p_tail  = xq <<< 1;
    side_nxt.tt      = t_r[TURN_W-1] ? -$signed({tsq, 1'b0}) : $signed({tsq, 1'b0});
    side_nxt.tabs    = tm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    s1_r    <= s_nxt;
    side1_r <= side_nxt;
  end

  // square root of s in q16
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  kwd_side_t         sq_side;

  kwd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v1_r),
    .in_s     (s1_r),
    .in_side  (side1_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // product stage: projection times root, divisor sum
  logic signed [PROD_W-1:0] pr_r, pl_r, pt_r;
  logic signed [TT_W-1:0]   tt_r;
  logic [DSUM_W-1:0]        dsum_r;
  logic                     vm_r;
  logic signed [PROD_W-1:0] root_s;

  assign root_s = $signed(PROD_W'(sq_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= sq_vld;
    end
    pr_r   <= PROD_W'(sq_side.p_right) * root_s;
    pl_r   <= PROD_W'(sq_side.p_left) * root_s;
    pt_r   <= PROD_W'(sq_side.p_tail) * root_s;
    tt_r   <= sq_side.tt;
    dsum_r <= DSUM_W'(sq_root) + (DSUM_W'(sq_side.tabs) << 16);
  end

  // numerator stage: add turn term, split into sign and magnitude
  localparam int SUM_W = NUM_W + 1;
  logic signed [SUM_W-1:0] ttq, nr, nl, nt;
  logic [NUM_W-1:0]        nr_r, nl_r, nt_r;
  kwd_ctl_t                cr_r, cl_r, ct_r;
  logic [DSUM_W-1:0]       dsum_n_r;

  always_comb begin
    ttq = SUM_W'(tt_r) <<< 32;
    nr  = SUM_W'(pr_r) + ttq;
    nl  = SUM_W'(pl_r) + ttq;
    nt  = SUM_W'(pt_r) + ttq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r.vld <= 1'b0;
      cl_r.vld <= 1'b0;
      ct_r.vld <= 1'b0;
    end else begin
      cr_r.vld <= vm_r;
      cl_r.vld <= vm_r;
      ct_r.vld <= vm_r;
    end
    cr_r.neg  <= nr[SUM_W-1];
    cl_r.neg  <= nl[SUM_W-1];
    ct_r.neg  <= nt[SUM_W-1];
    cr_r.zero <= (dsum_r == '0);
    cl_r.zero <= (dsum_r == '0);
    ct_r.zero <= (dsum_r == '0);
    nr_r      <= nr[SUM_W-1] ? NUM_W'(-nr) : NUM_W'(nr);
    nl_r      <= nl[SUM_W-1] ? NUM_W'(-nl) : NUM_W'(nl);
    nt_r      <= nt[SUM_W-1] ? NUM_W'(-nt) : NUM_W'(nt);
    dsum_n_r  <= dsum_r;
  end

  logic                     dr_vld, dl_vld, dt_vld;
  logic signed [AXIS_W-1:0] dr, dl, dt;

  kwd_div u_div_right (
    .clk(clk), .rst_n(rst_n), .in_ctl(cr_r), .in_num(nr_r), .in_dsum(dsum_n_r),
    .out_vld(dr_vld), .out_drive(dr)
  );

  kwd_div u_div_left (
    .clk(clk), .rst_n(rst_n), .in_ctl(cl_r), .in_num(nl_r), .in_dsum(dsum_n_r),
    .out_vld(dl_vld), .out_drive(dl)
  );

  kwd_div u_div_tail (
    .clk(clk), .rst_n(rst_n), .in_ctl(ct_r), .in_num(nt_r), .in_dsum(dsum_n_r),
    .out_vld(dt_vld), .out_drive(dt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dr_vld;
    end
    out_right_drive <= dr;
    out_left_drive  <= dl;
    out_tail_drive  <= dt;
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dr_vld == dl_vld) && (dr_vld == dt_vld))
    else $error("wheel lanes out of step");

  a_tail_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r && tt_r == '0 && pt_r == '0) |=> (nt_r == '0))
    else $error("tail numerator not zero");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v0_r)
    else $error("accepted transfer dropped");

endmodule

`default_nettype wire
